@@ src/host_hit_rate_limiter_core_defines.svh @@
// Assertion macros for the host hit rate limiter.
// Used by the top level only; relies on clk and rst_n in scope.
`ifndef HOST_HIT_RATE_LIMITER_CORE_DEFINES_SVH
`define HOST_HIT_RATE_LIMITER_CORE_DEFINES_SVH

// Same-cycle implication
`define HHRL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define HHRL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/hhrl_pkg.sv @@
// Shared types and constants of the host hit rate limiter.
// No dependencies.
`timescale 1ns / 1ps

package hhrl_pkg;

    localparam int WATCH_DEPTH_DEF = 64;

    localparam int KEY_W   = 64;
    localparam int TIME_W  = 32;
    localparam int HITS_W  = 16;
    localparam int ENTRY_W = KEY_W + TIME_W + HITS_W;
    localparam int IN_W    = 112;
    localparam int OUT_W   = 96;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BASE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ID      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIST_LIMIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_PCT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE          = 3'd6;

    // Mode bit positions
    localparam int MODE_WARN_FAIL  = 0;
    localparam int MODE_KEEP_BLOCK = 1;
    localparam int MODE_WARN_FULL  = 2;
    localparam int MODE_BLOCK_FULL = 3;
    localparam int MODE_LOCAL      = 4;

    // Result status codes
    localparam logic [1:0] STAT_EXISTING = 2'd0;
    localparam logic [1:0] STAT_ADDED    = 2'd1;
    localparam logic [1:0] STAT_LIMIT    = 2'd2;
    localparam logic [1:0] STAT_FULL     = 2'd3;

    localparam logic [HITS_W-1:0] SAT_COUNT = 16'hFFFF;
    localparam logic [15:0]       RAND_MID  = 16'h8000;
    localparam logic [22:0]       DUR_DIVISOR = 23'd6553500;  // 100 * 0xFFFF

    // ceil(2^69 / divisor): exact floor quotient for any 46-bit dividend
    localparam logic [47:0] DUR_RECIP =
        48'(((70'd1 << 69) + 70'(DUR_DIVISOR) - 70'd1) / 70'(DUR_DIVISOR));

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXP_RD,
        ST_EXP_CHK,
        ST_LK_RD,
        ST_LK_CHK,
        ST_ADD,
        ST_FIN
    } hhrl_state_t;

    typedef enum logic [2:0] {
        DUR_IDLE,
        DUR_MUL1,
        DUR_MUL2,
        DUR_DIV,
        DUR_DONE
    } hhrl_dur_phase_t;

    typedef struct packed {
        logic load;
        logic rd_head;
        logic pop;
        logic rd_idx;
        logic idx_inc;
        logic hit_upd;
        logic add;
        logic out_load;
    } hhrl_cmd_t;

    typedef struct packed {
        logic occ_zero;
        logic expired;
        logic idx_end;
        logic key_match;
        logic dur_done;
        logic out_busy;
    } hhrl_sts_t;

endpackage

@@ src/host_hit_rate_limiter_core.sv @@
// Channel  | Dir | Handshake              | Payload
// s_       | in  | s_tvalid / s_tready    | s_tdata: host_key, now_seconds, rand_word
// m_       | out | m_tvalid / m_tready    | m_tdata: result item
// cfg_     | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
// One item at a time. An item's time is set by the duration unit (two multiplies,
// four reciprocal partial products) and the single read port of the watch store;
// a stalled m_tready adds its stall.
// Reset clears ring head, occupancy and config; the store needs no clearing pass.
// A waiting result sits in the output register while the next request is taken.
`timescale 1ns / 1ps
`include "host_hit_rate_limiter_core_defines.svh"

module host_hit_rate_limiter_core #(
    parameter int WATCH_DEPTH = hhrl_pkg::WATCH_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [63:0] host_key, [95:64] now_seconds, [111:96] rand_word
    input  logic [hhrl_pkg::IN_W-1:0]       s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [1:0] status, [17:2] hit_count, [18] block_now, [51:19] block_until,
    // [76:52] block_duration, [92:77] block_table, [93] block_local,
    // [94] warn_blocked_hit, [95] warn_list_full
    output logic [hhrl_pkg::OUT_W-1:0]      m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hhrl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hhrl_pkg::CFG_DATA_W-1:0] cfg_data
);

    hhrl_pkg::hhrl_cmd_t cmd;
    hhrl_pkg::hhrl_sts_t sts;

    assign cfg_ready = 1'b1;

    hhrl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    hhrl_datapath #(
        .WATCH_DEPTH (WATCH_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_tdata),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

    // Checks
    `HHRL_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second request taken early")
    `HHRL_ASSERT_NOW(a_block_fields, m_tvalid && !m_tdata[18], m_tdata[93:19] == '0, "block fields set without block")
    `HHRL_ASSERT_NOW(a_added_count, m_tvalid && m_tdata[1:0] == hhrl_pkg::STAT_ADDED, m_tdata[17:2] == 16'd1, "new host count not one")
    `HHRL_ASSERT_NOW(a_full_quiet, m_tvalid && m_tdata[1:0] == hhrl_pkg::STAT_FULL, m_tdata[18] == 1'b0 && m_tdata[17:2] == 16'd0, "store full result not quiet")

endmodule

@@ src/hhrl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hhrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/hhrl_dur.sv @@
// Block duration unit: offset * pct * base, then divide by 100*0xFFFF through
// a reciprocal multiply built from four partial products. Depends on hhrl_pkg.
`timescale 1ns / 1ps

module hhrl_dur (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] rand_word,
    input  logic [6:0]  pct,
    input  logic [23:0] base,
    output logic        done,
    output logic [24:0] dur
);

    hhrl_pkg::hhrl_dur_phase_t phase_reg, phase_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg;
    logic [15:0] mag_reg;
    logic [21:0] m1_reg;
    logic [45:0] prod_reg;
    logic [92:0] acc_reg;
    logic [22:0] pp_a;
    logic [23:0] pp_b;
    logic [46:0] pp;
    logic [92:0] pp_sh;
    logic [23:0] quo;
    logic [25:0] dsum;

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        if (start)
        begin
            phase_next = hhrl_pkg::DUR_MUL1;
        end
        else
        begin
            case (phase_reg)
                hhrl_pkg::DUR_MUL1: phase_next = hhrl_pkg::DUR_MUL2;
                hhrl_pkg::DUR_MUL2:
                begin
                    phase_next = hhrl_pkg::DUR_DIV;
                    cnt_next   = 6'd3;
                end
                hhrl_pkg::DUR_DIV:
                begin
                    if (cnt_reg == 6'd0)
                    begin
                        phase_next = hhrl_pkg::DUR_DONE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 6'd1;
                    end
                end
                default: phase_next = phase_reg;
            endcase
        end
    end

    // Outputs
    always_comb
    begin
        done = (phase_reg == hhrl_pkg::DUR_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= hhrl_pkg::DUR_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Operand halves for the current partial product
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd3:
            begin
                pp_a = prod_reg[22:0];
                pp_b = hhrl_pkg::DUR_RECIP[23:0];
            end
            2'd2:
            begin
                pp_a = prod_reg[22:0];
                pp_b = hhrl_pkg::DUR_RECIP[47:24];
            end
            2'd1:
            begin
                pp_a = prod_reg[45:23];
                pp_b = hhrl_pkg::DUR_RECIP[23:0];
            end
            default:
            begin
                pp_a = prod_reg[45:23];
                pp_b = hhrl_pkg::DUR_RECIP[47:24];
            end
        endcase
    end

    assign pp = {24'd0, pp_a} * {23'd0, pp_b};

    // Align the partial product; high x high stays below 2^46
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd3:    pp_sh = {46'd0, pp};
            2'd2:    pp_sh = {22'd0, pp, 24'd0};
            2'd1:    pp_sh = {23'd0, pp, 23'd0};
            default: pp_sh = {pp[45:0], 47'd0};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= ~rand_word[15];
            mag_reg <= rand_word[15] ? (rand_word - hhrl_pkg::RAND_MID)
                                     : (hhrl_pkg::RAND_MID - rand_word);
        end
        else
        begin
            case (phase_reg)
                hhrl_pkg::DUR_MUL1: m1_reg <= {6'd0, mag_reg} * {15'd0, pct};
                hhrl_pkg::DUR_MUL2:
                begin
                    prod_reg <= {24'd0, m1_reg} * {22'd0, base};
                    acc_reg  <= '0;
                end
                hhrl_pkg::DUR_DIV: acc_reg <= acc_reg + pp_sh;
                default: ;
            endcase
        end
    end

    // Quotient is the product scaled down by 2^69
    assign quo = acc_reg[92:69];

    // Apply signed offset, truncated toward zero, clamp at zero
    assign dsum = neg_reg ? ({2'b00, base} - {2'b00, quo})
                          : ({2'b00, base} + {2'b00, quo});
    assign dur  = dsum[25] ? 25'd0 : dsum[24:0];

endmodule

@@ src/hhrl_datapath.sv @@
// Datapath: config registers, watch store and ring pointers, result register.
// Depends on hhrl_pkg, hhrl_ram and hhrl_dur.
`timescale 1ns / 1ps

module hhrl_datapath #(
    parameter int WATCH_DEPTH = hhrl_pkg::WATCH_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  hhrl_pkg::hhrl_cmd_t               cmd,
    output hhrl_pkg::hhrl_sts_t               sts,
    input  logic [hhrl_pkg::IN_W-1:0]         in_data,
    input  logic                              cfg_wr,
    input  logic [hhrl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hhrl_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [hhrl_pkg::OUT_W-1:0]        out_data
);

    localparam int AW = $clog2(WATCH_DEPTH);
    localparam int OW = $clog2(WATCH_DEPTH + 1);
    localparam int SW = AW + 2;

    // Config registers
    logic [15:0] thr_reg;
    logic [23:0] window_reg;
    logic [23:0] base_reg;
    logic [15:0] table_reg;
    logic [6:0]  limit_reg;
    logic [6:0]  pct_reg;
    logic [4:0]  mode_reg;

    // Item and ring state
    logic [63:0]    key_reg;
    logic [31:0]    now_reg;
    logic [AW-1:0]  head_reg;
    logic [OW-1:0]  occ_reg;
    logic [OW-1:0]  idx_reg;

    // Result
    logic [1:0]  res_status_reg;
    logic [15:0] res_count_reg;
    logic        res_block_reg;
    logic        res_warn_hit_reg;
    logic        res_warn_full_reg;
    logic        out_valid_reg;
    logic [hhrl_pkg::OUT_W-1:0] out_data_reg;

    logic [SW-1:0] idx_sum, idx_wrap, occ_sum, occ_wrap;
    logic [AW-1:0] slot_idx, slot_tail, raddr, waddr;
    logic          we;
    logic [hhrl_pkg::ENTRY_W-1:0] wdata, rdata;
    logic [63:0]   rd_key;
    logic [31:0]   rd_time;
    logic [15:0]   rd_hits;
    logic          sat;
    logic [15:0]   new_count;
    logic [16:0]   thr_p1;
    logic          dur_done;
    logic [24:0]   dur;
    logic [32:0]   blk_until;
    logic          limit_hit, store_full;

    assign {rd_hits, rd_time, rd_key} = rdata;

    // Ring slot arithmetic
    assign idx_sum  = SW'(head_reg) + SW'(idx_reg);
    assign idx_wrap = (idx_sum >= SW'(WATCH_DEPTH)) ? idx_sum - SW'(WATCH_DEPTH) : idx_sum;
    assign slot_idx = idx_wrap[AW-1:0];
    assign occ_sum  = SW'(head_reg) + SW'(occ_reg);
    assign occ_wrap = (occ_sum >= SW'(WATCH_DEPTH)) ? occ_sum - SW'(WATCH_DEPTH) : occ_sum;
    assign slot_tail = occ_wrap[AW-1:0];

    assign raddr = cmd.rd_head ? head_reg : slot_idx;

    // Hit count update
    assign sat       = (rd_hits == hhrl_pkg::SAT_COUNT);
    assign new_count = sat ? hhrl_pkg::SAT_COUNT : rd_hits + 16'd1;
    assign thr_p1    = {1'b0, thr_reg} + 17'd1;

    assign limit_hit  = (limit_reg != 7'd0) && (32'(occ_reg) >= 32'(limit_reg));
    assign store_full = (occ_reg == OW'(WATCH_DEPTH));

    // Store writes
    always_comb
    begin
        we    = 1'b0;
        waddr = slot_idx;
        wdata = {new_count, rd_time, rd_key};
        if (cmd.hit_upd)
        begin
            we = 1'b1;
        end
        else if (cmd.add && !limit_hit && !store_full)
        begin
            we    = 1'b1;
            waddr = slot_tail;
            wdata = {16'd1, now_reg, key_reg};
        end
    end

    hhrl_ram #(
        .WIDTH (hhrl_pkg::ENTRY_W),
        .DEPTH (WATCH_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    hhrl_dur u_dur (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.load),
        .rand_word (in_data[111:96]),
        .pct       (pct_reg),
        .base      (base_reg),
        .done      (dur_done),
        .dur       (dur)
    );

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= 16'd4;
            window_reg <= 24'd60;
            base_reg   <= 24'd600;
            table_reg  <= 16'd1;
            limit_reg  <= 7'd0;
            pct_reg    <= 7'd30;
            mode_reg   <= 5'd14;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                hhrl_pkg::CFG_HIT_THRESHOLD: thr_reg    <= cfg_data[15:0];
                hhrl_pkg::CFG_WINDOW:        window_reg <= cfg_data;
                hhrl_pkg::CFG_BLOCK_BASE:    base_reg   <= cfg_data;
                hhrl_pkg::CFG_TABLE_ID:      table_reg  <= cfg_data[15:0];
                hhrl_pkg::CFG_LIST_LIMIT:    limit_reg  <= cfg_data[6:0];
                hhrl_pkg::CFG_RANDOM_PCT:    pct_reg    <= cfg_data[6:0];
                hhrl_pkg::CFG_MODE:          mode_reg   <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Ring pointers and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            occ_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + OW'(1);
            end
            if (cmd.pop)
            begin
                head_reg <= (head_reg == AW'(WATCH_DEPTH - 1)) ? '0 : head_reg + AW'(1);
                occ_reg  <= occ_reg - OW'(1);
            end
            else if (cmd.add && !limit_hit && !store_full)
            begin
                occ_reg <= occ_reg + OW'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item capture and result decision
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg  <= in_data[63:0];
            now_reg  <= in_data[95:64];
        end
        if (cmd.hit_upd)
        begin
            res_status_reg    <= hhrl_pkg::STAT_EXISTING;
            res_count_reg     <= new_count;
            res_warn_full_reg <= 1'b0;
            if (!sat && new_count == thr_reg)
            begin
                res_block_reg    <= 1'b1;
                res_warn_hit_reg <= 1'b0;
            end
            else if (sat || new_count > thr_reg)
            begin
                res_block_reg    <= mode_reg[hhrl_pkg::MODE_KEEP_BLOCK];
                res_warn_hit_reg <= mode_reg[hhrl_pkg::MODE_WARN_FAIL] && !sat
                                    && ({1'b0, new_count} == thr_p1);
            end
            else
            begin
                res_block_reg    <= 1'b0;
                res_warn_hit_reg <= 1'b0;
            end
        end
        else if (cmd.add)
        begin
            res_warn_hit_reg <= 1'b0;
            if (limit_hit)
            begin
                res_status_reg    <= hhrl_pkg::STAT_LIMIT;
                res_count_reg     <= '0;
                res_block_reg     <= mode_reg[hhrl_pkg::MODE_BLOCK_FULL];
                res_warn_full_reg <= mode_reg[hhrl_pkg::MODE_WARN_FULL];
            end
            else if (store_full)
            begin
                res_status_reg    <= hhrl_pkg::STAT_FULL;
                res_count_reg     <= '0;
                res_block_reg     <= 1'b0;
                res_warn_full_reg <= 1'b0;
            end
            else
            begin
                res_status_reg    <= hhrl_pkg::STAT_ADDED;
                res_count_reg     <= 16'd1;
                res_block_reg     <= (thr_reg == 16'd1);
                res_warn_full_reg <= 1'b0;
            end
        end
        if (cmd.out_load)
        begin
            out_data_reg <= {res_warn_full_reg,
                             res_warn_hit_reg,
                             res_block_reg & mode_reg[hhrl_pkg::MODE_LOCAL],
                             res_block_reg ? table_reg : 16'd0,
                             res_block_reg ? ((base_reg != 24'd0) ? dur : 25'd0) : 25'd0,
                             res_block_reg ? blk_until : 33'd0,
                             res_block_reg,
                             res_count_reg,
                             res_status_reg};
        end
    end

    assign blk_until = (base_reg != 24'd0) ? ({1'b0, now_reg} + 33'(dur)) : 33'd0;

    // Status to controller
    assign sts.occ_zero  = (occ_reg == '0);
    assign sts.expired   = (({1'b0, rd_time} + 33'(window_reg)) < {1'b0, now_reg});
    assign sts.idx_end   = (idx_reg >= occ_reg);
    assign sts.key_match = (rd_key == key_reg);
    assign sts.dur_done  = dur_done;
    assign sts.out_busy  = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ src/hhrl_ctrl.sv @@
// Controller state machine: expiry sweep, lookup walk, append, result handoff.
// Depends on hhrl_pkg.
`timescale 1ns / 1ps

module hhrl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output hhrl_pkg::hhrl_cmd_t  cmd,
    input  hhrl_pkg::hhrl_sts_t  sts
);

    hhrl_pkg::hhrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hhrl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hhrl_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = hhrl_pkg::ST_EXP_RD;
                end
            end
            hhrl_pkg::ST_EXP_RD:
            begin
                state_next = sts.occ_zero ? hhrl_pkg::ST_LK_RD : hhrl_pkg::ST_EXP_CHK;
            end
            hhrl_pkg::ST_EXP_CHK:
            begin
                state_next = sts.expired ? hhrl_pkg::ST_EXP_RD : hhrl_pkg::ST_LK_RD;
            end
            hhrl_pkg::ST_LK_RD:
            begin
                state_next = sts.idx_end ? hhrl_pkg::ST_ADD : hhrl_pkg::ST_LK_CHK;
            end
            hhrl_pkg::ST_LK_CHK:
            begin
                state_next = sts.key_match ? hhrl_pkg::ST_FIN : hhrl_pkg::ST_LK_RD;
            end
            hhrl_pkg::ST_ADD:
            begin
                state_next = hhrl_pkg::ST_FIN;
            end
            hhrl_pkg::ST_FIN:
            begin
                if (sts.dur_done && !sts.out_busy)
                begin
                    state_next = hhrl_pkg::ST_IDLE;
                end
            end
            default: state_next = hhrl_pkg::ST_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            hhrl_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            hhrl_pkg::ST_EXP_RD:  cmd.rd_head = !sts.occ_zero;
            hhrl_pkg::ST_EXP_CHK: cmd.pop     = sts.expired;
            hhrl_pkg::ST_LK_RD:   cmd.rd_idx  = !sts.idx_end;
            hhrl_pkg::ST_LK_CHK:
            begin
                cmd.hit_upd = sts.key_match;
                cmd.idx_inc = !sts.key_match;
            end
            hhrl_pkg::ST_ADD:     cmd.add      = 1'b1;
            hhrl_pkg::ST_FIN:     cmd.out_load = sts.dur_done && !sts.out_busy;
            default: ;
        endcase
    end

endmodule

@@ sim/host_hit_rate_limiter_core_tb.sv @@
// Self-checking testbench for the host hit rate limiter core.
// Predicts each result from a behavioral watch list; depends on hhrl_pkg and the core.
`timescale 1ns / 1ps

module host_hit_rate_limiter_core_tb;

    localparam int DEPTH = hhrl_pkg::WATCH_DEPTH_DEF;
    localparam int LIMIT_CYCLES = 2000000;

    typedef struct packed {
        logic        warn_full;
        logic        warn_hit;
        logic        blk_local;
        logic [15:0] blk_table;
        logic [24:0] blk_dur;
        logic [32:0] blk_until;
        logic        blk;
        logic [15:0] count;
        logic [1:0]  status;
    } verdict_t;

    logic clk, rst_n;
    logic s_tvalid, s_tready, m_tvalid, m_tready, cfg_valid, cfg_ready;
    logic [hhrl_pkg::IN_W-1:0] s_tdata;
    logic [hhrl_pkg::OUT_W-1:0] m_tdata;
    logic [hhrl_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [hhrl_pkg::CFG_DATA_W-1:0] cfg_data;

    host_hit_rate_limiter_core dut (.*);

    // predictor state
    logic [63:0] w_key [DEPTH];
    logic [31:0] w_first [DEPTH];
    logic [15:0] w_hits [DEPTH];
    int unsigned w_head, w_occ;
    logic [15:0] r_thresh, r_table;
    logic [23:0] r_window, r_base;
    logic [6:0]  r_limit, r_pct;
    logic [4:0]  r_mode;

    verdict_t expected_q[$];
    int errors = 0;
    int unsigned cycles = 0;
    bit no_idle = 0;
    logic [63:0] recent_keys[$];

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // run-length guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("** host_hit_rate_limiter_core: FAILED **");
            $finish;
        end
    end

    // receiver: random stall, checks each result against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t unexpected result %h", $time, m_tdata);
                    errors++;
                end
                else
                begin
                    verdict_t e;
                    e = expected_q.pop_front();
                    if (e !== verdict_t'(m_tdata))
                    begin
                        $display("%0t mismatch exp %h act %h", $time, e, m_tdata);
                        errors++;
                    end
                end
            end
            m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 23);
        end
    end

    function automatic logic [24:0] rand_duration(logic [15:0] rw);
        longint off, delta, d;
        off = longint'(rw) - 64'sd32768;
        delta = (off * longint'(r_pct) * longint'(r_base)) / 64'sd6553500;
        d = longint'(r_base) + delta;
        if (d < 0)
            d = 0;
        return d[24:0];
    endfunction

    function automatic verdict_t judge_hit(logic [63:0] key, logic [31:0] now,
                                           logic [15:0] rw);
        verdict_t v;
        bit found, blk, wh, wf, sat;
        logic [24:0] dur;
        logic [32:0] blk_end;
        logic [16:0] nc;
        int unsigned s;
        v = '0; found = 0; blk = 0; wh = 0; wf = 0; dur = 0; blk_end = 0;
        while (w_occ > 0 && ({32'd0, w_first[w_head]} + r_window) < {32'd0, now})
        begin
            w_head = (w_head + 1) % DEPTH;
            w_occ--;
        end
        if (r_base != 0)
        begin
            dur = rand_duration(rw);
            blk_end = {1'b0, now} + dur;
        end
        for (int i = 0; i < w_occ && !found; i++)
        begin
            s = (w_head + i) % DEPTH;
            if (w_key[s] == key)
            begin
                sat = (w_hits[s] == hhrl_pkg::SAT_COUNT);
                nc = sat ? hhrl_pkg::SAT_COUNT : w_hits[s] + 1;
                w_hits[s] = nc[15:0];
                v.count = nc[15:0];
                found = 1;
                if (!sat && nc == r_thresh)
                    blk = 1;
                else if (sat || nc > r_thresh)
                begin
                    if (r_mode[hhrl_pkg::MODE_WARN_FAIL] && !sat && nc == r_thresh + 17'd1)
                        wh = 1;
                    if (r_mode[hhrl_pkg::MODE_KEEP_BLOCK])
                        blk = 1;
                end
            end
        end
        if (found)
            v.status = hhrl_pkg::STAT_EXISTING;
        else if (r_limit > 0 && w_occ >= r_limit)
        begin
            v.status = hhrl_pkg::STAT_LIMIT;
            wf = r_mode[hhrl_pkg::MODE_WARN_FULL];
            blk = r_mode[hhrl_pkg::MODE_BLOCK_FULL];
        end
        else if (w_occ >= DEPTH)
            v.status = hhrl_pkg::STAT_FULL;
        else
        begin
            s = (w_head + w_occ) % DEPTH;
            w_key[s] = key; w_first[s] = now; w_hits[s] = 1;
            w_occ++;
            v.count = 1;
            v.status = hhrl_pkg::STAT_ADDED;
            if (r_thresh == 1)
                blk = 1;
        end
        v.blk = blk;
        if (blk)
        begin
            v.blk_until = blk_end;
            v.blk_dur = dur;
            v.blk_table = r_table;
            v.blk_local = r_mode[hhrl_pkg::MODE_LOCAL];
        end
        v.warn_hit = wh;
        v.warn_full = wf;
        return v;
    endfunction

    // one request on the item channel, with random idle before it
    task automatic send_hit(logic [63:0] key, logic [31:0] now, logic [15:0] rw);
        @(posedge clk);
        while (!no_idle && $urandom_range(99) < 23)
            @(posedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {rw, now, key};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_q.push_back(judge_hit(key, now, rw));
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic [hhrl_pkg::CFG_IDX_W-1:0] idx, logic [23:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            hhrl_pkg::CFG_HIT_THRESHOLD: r_thresh = val[15:0];
            hhrl_pkg::CFG_WINDOW:        r_window = val;
            hhrl_pkg::CFG_BLOCK_BASE:    r_base = val;
            hhrl_pkg::CFG_TABLE_ID:      r_table = val[15:0];
            hhrl_pkg::CFG_LIST_LIMIT:    r_limit = val[6:0];
            hhrl_pkg::CFG_RANDOM_PCT:    r_pct = val[6:0];
            hhrl_pkg::CFG_MODE:          r_mode = val[4:0];
            default: ;
        endcase
    endtask

    task automatic set_all(logic [15:0] th, logic [23:0] win, logic [23:0] base,
                           logic [15:0] tbl, logic [6:0] lim, logic [6:0] pct,
                           logic [4:0] mode);
        drain();
        write_reg(hhrl_pkg::CFG_HIT_THRESHOLD, th);
        write_reg(hhrl_pkg::CFG_WINDOW, win);
        write_reg(hhrl_pkg::CFG_BLOCK_BASE, base);
        write_reg(hhrl_pkg::CFG_TABLE_ID, tbl);
        write_reg(hhrl_pkg::CFG_LIST_LIMIT, lim);
        write_reg(hhrl_pkg::CFG_RANDOM_PCT, pct);
        write_reg(hhrl_pkg::CFG_MODE, mode);
    endtask

    // directed: threshold, warn, rand extremes, list limit, expiry, zero base
    task automatic test_directed();
        for (int i = 0; i < 6; i++)
            send_hit(64'hFFFF_FFFF_FFFF_FFFF, 32'd100, (i == 0) ? 16'h0000 : 16'hFFFF);
        send_hit(64'd0, 32'hFFFF_FFFF, 16'h8000);
        set_all(16'd1, 24'd0, 24'hFFFFFF, 16'hFFFF, 7'd2, 7'd100, 5'd31);
        send_hit(64'd5, 32'd10, 16'h0000);
        send_hit(64'd6, 32'd10, 16'hFFFF);
        send_hit(64'd7, 32'd10, 16'h1234);
        send_hit(64'd5, 32'd10, 16'hFFFF);
        send_hit(64'd8, 32'd12, 16'h0001);
        set_all(16'd0, 24'd5, 24'd0, 16'd0, 7'd64, 7'd0, 5'd0);
        send_hit(64'd9, 32'd20, 16'h0);
        send_hit(64'd9, 32'd20, 16'h0);
        set_all(16'd3, 24'hFFFFFF, 24'd1, 16'd7, 7'd100, 7'd50, 5'd1);
        for (int i = 0; i < 5; i++)
            send_hit(64'hA5, 32'hFFFF_FF00, 16'($urandom));
    endtask

    // fills the store past capacity, then hits one stored key repeatedly
    task automatic test_capacity();
        set_all(16'hFFFF, 24'hFFFFFF, 24'd300, 16'd2, 7'd0, 7'd30, 5'd2);
        for (int i = 0; i < 66; i++)
            send_hit(64'h1000 + i, 32'd50, 16'($urandom));
        // repeated hits with ring full; pause first so the sender waits on results
        drain();
        set_all(16'd2, 24'hFFFFFF, 24'd300, 16'd2, 7'd0, 7'd30, 5'd3);
        for (int i = 0; i < 5; i++)
            send_hit(64'h1000, 32'd50, 16'($urandom));
    endtask

    // random hits with a small key set and slowly moving time
    task automatic test_random(int n);
        logic [31:0] now;
        logic [63:0] key;
        now = $urandom;
        for (int i = 0; i < n; i++)
        begin
            if (i % 150 == 0)
            begin
                set_all(16'($urandom_range(6)), 24'($urandom_range(40)),
                        ($urandom_range(3) == 0) ? 24'd0 : 24'($urandom),
                        16'($urandom), 7'($urandom_range(70)),
                        7'($urandom_range(100)), 5'($urandom));
                w_occ = w_occ; // state persists across settings
            end
            no_idle = (i >= 300 && i < 380);
            now = now + $urandom_range(3);
            if ($urandom_range(9) == 0)
                key = {$urandom, $urandom};
            else if ($urandom_range(4) == 0 && recent_keys.size() > 0)
                key = recent_keys[$urandom_range(recent_keys.size() - 1)];
            else
                key = 64'($urandom_range(40)) ^ 64'hFEDC_BA98_7654_3210;
            recent_keys.push_back(key);
            if (recent_keys.size() > 16)
                void'(recent_keys.pop_front());
            send_hit(key, now, 16'($urandom));
        end
        no_idle = 0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        w_head = 0; w_occ = 0;
        r_thresh = 16'd4; r_window = 24'd60; r_base = 24'd600; r_table = 16'd1;
        r_limit = 7'd0; r_pct = 7'd30; r_mode = 5'd14;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_capacity();
        test_random(510);
        drain();
        if (errors == 0)
            $display("** host_hit_rate_limiter_core: PASSED **");
        else
            $display("** host_hit_rate_limiter_core: FAILED **");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+src
src/hhrl_pkg.sv
src/hhrl_ram.sv
src/hhrl_dur.sv
src/hhrl_datapath.sv
src/hhrl_ctrl.sv
src/host_hit_rate_limiter_core.sv
sim/host_hit_rate_limiter_core_tb.sv
